// ----- rtl/core/crva_pkg.sv -----
// ----------------------------------------------------------------------------
// crva_pkg
// shared types and constants of the sparse row vector accumulator
// ----------------------------------------------------------------------------
package crva_pkg;

    // widest lane count that the packed words carry
    localparam int unsigned MAX_LANES = 16;
    localparam int unsigned Q_W       = 16;
    localparam int unsigned ACC_W     = 32;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned CHUNK_W   = 8;
    localparam int unsigned CFG_W     = 9;

    // configuration register map
    localparam logic [1:0] ADDR_CHUNKS_PER_ROW = 2'd0;

    // op codes of an input word
    localparam logic OP_MULTIPLY  = 1'b0;
    localparam logic OP_EMPTY_ROW = 1'b1;

    // sixteen Q8.8 lanes, lane k at bits 16k
    typedef logic [MAX_LANES-1:0][Q_W-1:0] t_lane_vec;

    // per-cycle control from the top level to every lane
    typedef struct packed {
        logic adv;      // whole pipeline moves this edge
        logic take;     // an input word is accepted this edge
        logic first;    // accepted word overwrites its slot
        logic fwd_hit;  // accepted word reads the slot being written now
        logic write;    // the word in the accumulate stage writes its slot
    } t_lane_ctrl;

    // sideband of the word leaving the accumulate stage toward the merge
    typedef struct packed {
        logic               emit;
        logic               zero;
        logic [CHUNK_W-1:0] pos;
        logic               last_chunk;
    } t_merge_in;

endpackage

// ----- rtl/core/crva_lane.sv -----
// ----------------------------------------------------------------------------
// crva_lane
// one lane: multiply, accumulator memory, saturating add and Q8.8 rounding
// ----------------------------------------------------------------------------
module crva_lane #(
    parameter int unsigned ADDR_W    = 8,
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  crva_pkg::t_lane_ctrl                i_ctrl,
    input  logic [ADDR_W-1:0]                   i_rd_addr,
    input  logic [ADDR_W-1:0]                   i_wr_addr,
    input  logic signed [crva_pkg::Q_W-1:0]     i_weight,
    input  logic signed [crva_pkg::Q_W-1:0]     i_dense,
    output logic [crva_pkg::Q_W-1:0]            o_q
);
    import crva_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic signed [ACC_W-1:0] r_mem [0:DEPTH-1];

    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_rdata;
    logic                    r_first;
    logic                    r_fwd;
    logic signed [ACC_W-1:0] r_fwd_data;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [ACC_W-1:0] old_val;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] sum_sat;
    logic signed [ACC_W-1:0] acc_a;
    logic signed [ACC_W-1:0] shifted;

    // accumulator slot memory, read on accept and written from the add stage
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write) begin
            r_mem[i_wr_addr] <= acc_a;
        end
        if (i_ctrl.take) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    // product and forwarding capture on accept
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_prod     <= i_weight * i_dense;
            r_first    <= i_ctrl.first;
            r_fwd      <= i_ctrl.fwd_hit;
            r_fwd_data <= acc_a;
        end
    end

    // saturating accumulate, or overwrite on the row's first nonzero
    always_comb begin
        old_val = r_fwd ? r_fwd_data : r_rdata;
        sum     = (ACC_W+1)'(old_val) + (ACC_W+1)'(r_prod);
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sum_sat = sum[ACC_W-1:0];
        end
        acc_a = r_first ? r_prod : sum_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_acc <= acc_a;
        end
    end

    // floor shift by the fraction width, then clamp to 16 bits
    always_comb begin
        shifted = r_acc >>> FRAC_BITS;
        if (shifted > 32'sd32767) begin
            o_q = 16'h7FFF;
        end else if (shifted < -32'sd32768) begin
            o_q = 16'h8000;
        end else begin
            o_q = shifted[Q_W-1:0];
        end
    end

endmodule

// ----- rtl/core/crva_merge.sv -----
// ----------------------------------------------------------------------------
// crva_merge
// gathers the lane results into packed words and holds the output register
// ----------------------------------------------------------------------------
module crva_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  crva_pkg::t_merge_in             i_side,
    input  crva_pkg::t_lane_vec             i_lanes,
    output logic                            o_valid,
    output logic [crva_pkg::WORD_W-1:0]     o_result_lanes_0_3,
    output logic [crva_pkg::WORD_W-1:0]     o_result_lanes_4_7,
    output logic [crva_pkg::WORD_W-1:0]     o_result_lanes_8_11,
    output logic [crva_pkg::WORD_W-1:0]     o_result_lanes_12_15,
    output logic [crva_pkg::CHUNK_W-1:0]    o_chunk_index,
    output logic                            o_row_done
);
    import crva_pkg::*;

    logic                   r_valid;
    t_lane_vec              r_lanes;
    logic [CHUNK_W-1:0]     r_chunk;
    logic                   r_done;
    t_lane_vec              n_lanes;

    // empty-row words give all zero lanes
    assign n_lanes = i_side.zero ? '0 : i_lanes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_side.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_side.emit) begin
            r_lanes <= n_lanes;
            r_chunk <= i_side.pos;
            r_done  <= i_side.last_chunk;
        end
    end

    assign o_valid              = r_valid;
    assign o_result_lanes_0_3   = r_lanes[3:0];
    assign o_result_lanes_4_7   = r_lanes[7:4];
    assign o_result_lanes_8_11  = r_lanes[11:8];
    assign o_result_lanes_12_15 = r_lanes[15:12];
    assign o_chunk_index        = r_chunk;
    assign o_row_done           = r_done;

endmodule

// ----- rtl/core/csr_row_vector_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// csr_row_vector_accumulator_top
// accumulates one output row of a sparse times dense product, 16 lanes wide
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   input     i_valid / o_stall    i_op, i_weight, i_first_nonzero,
//                                  i_last_nonzero, i_dense_lanes_*
//   output    o_valid / i_stall    o_result_lanes_*, o_chunk_index, o_row_done
//   config    psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// one word per cycle unless an output stall holds the pipeline; a result leaves once
// its word has passed the multiply and slot read, the saturating add and the output register
// a slot written by the word just ahead is forwarded around the memory read
// reset clears the control state only; slots hold garbage until written
// an output stall freezes the whole pipeline and is passed to o_stall
// ----------------------------------------------------------------------------
module csr_row_vector_accumulator_top #(
    parameter int unsigned LANES      = 16,
    parameter int unsigned MAX_CHUNKS = 256,
    parameter int unsigned FRAC_BITS  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [1:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_op,
    input  logic signed [15:0]              i_weight,
    input  logic                            i_first_nonzero,
    input  logic                            i_last_nonzero,
    input  logic [63:0]                     i_dense_lanes_0_3,
    input  logic [63:0]                     i_dense_lanes_4_7,
    input  logic [63:0]                     i_dense_lanes_8_11,
    input  logic [63:0]                     i_dense_lanes_12_15,
    // output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [63:0]                     o_result_lanes_0_3,
    output logic [63:0]                     o_result_lanes_4_7,
    output logic [63:0]                     o_result_lanes_8_11,
    output logic [63:0]                     o_result_lanes_12_15,
    output logic [7:0]                      o_chunk_index,
    output logic                            o_row_done
);
    import crva_pkg::*;

    localparam int unsigned DEPTH  = (MAX_CHUNKS < 256) ? MAX_CHUNKS : 256;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CFG_W-1:0] CAP = CFG_W'(DEPTH);

    logic [CFG_W-1:0]   r_cfg;
    logic [CHUNK_W-1:0] r_pos;
    logic [CFG_W-1:0]   eff;
    logic               last_chunk;
    logic               cfg_wr;

    logic               adv;
    logic               take;
    t_lane_ctrl         lane_ctrl;
    t_merge_in          merge_in;

    // stage a: multiply and slot read done, accumulate pending
    logic               r_a_valid;
    logic               r_a_op;
    logic               r_a_emit;
    logic [CHUNK_W-1:0] r_a_pos;
    logic               r_a_last;
    // stage b: accumulator registered, rounding pending
    logic               r_b_valid;
    logic               r_b_op;
    logic               r_b_emit;
    logic [CHUNK_W-1:0] r_b_pos;
    logic               r_b_last;

    t_lane_vec          dense_vec;
    t_lane_vec          q_vec;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CHUNKS_PER_ROW);
    assign prdata = (paddr == ADDR_CHUNKS_PER_ROW) ? {{(32-CFG_W){1'b0}}, r_cfg} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_W'(1);
        end else if (cfg_wr) begin
            r_cfg <= pwdata[CFG_W-1:0];
        end
    end

    // effective chunk count, zero counts as one, clamped to the slot depth
    always_comb begin
        if (r_cfg == '0) begin
            eff = CFG_W'(1);
        end else if (r_cfg > CAP) begin
            eff = CAP;
        end else begin
            eff = r_cfg;
        end
    end

    assign last_chunk = ({1'b0, r_pos} + CFG_W'(1)) >= eff;

    // pipeline moves unless a held result is stalled
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;
    assign take    = i_valid && adv;

    // chunk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (cfg_wr) begin
            r_pos <= '0;
        end else if (take) begin
            r_pos <= last_chunk ? '0 : r_pos + CHUNK_W'(1);
        end
    end

    // sideband valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= take;
            r_b_valid <= r_a_valid;
        end
    end

    // sideband payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_op   <= i_op;
            r_a_emit <= (i_op == OP_EMPTY_ROW) || i_last_nonzero;
            r_a_pos  <= r_pos;
            r_a_last <= last_chunk;
        end
        if (adv) begin
            r_b_op   <= r_a_op;
            r_b_emit <= r_a_emit;
            r_b_pos  <= r_a_pos;
            r_b_last <= r_a_last;
        end
    end

    // lane control
    always_comb begin
        lane_ctrl.adv     = adv;
        lane_ctrl.take    = take;
        lane_ctrl.first   = i_first_nonzero;
        lane_ctrl.fwd_hit = r_a_valid && (r_a_op == OP_MULTIPLY) && (r_a_pos == r_pos);
        lane_ctrl.write   = adv && r_a_valid && (r_a_op == OP_MULTIPLY);
    end

    assign dense_vec = {i_dense_lanes_12_15, i_dense_lanes_8_11,
                        i_dense_lanes_4_7, i_dense_lanes_0_3};

    // lane array, lanes past LANES read as zero
    for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
        if (k < LANES) begin : g_on
            crva_lane #(
                .ADDR_W    (ADDR_W),
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .i_clk     (i_clk),
                .i_ctrl    (lane_ctrl),
                .i_rd_addr (r_pos[ADDR_W-1:0]),
                .i_wr_addr (r_a_pos[ADDR_W-1:0]),
                .i_weight  (i_weight),
                .i_dense   (dense_vec[k]),
                .o_q       (q_vec[k])
            );
        end else begin : g_off
            assign q_vec[k] = '0;
        end
    end

    always_comb begin
        merge_in.emit       = r_b_valid && r_b_emit;
        merge_in.zero       = (r_b_op == OP_EMPTY_ROW);
        merge_in.pos        = r_b_pos;
        merge_in.last_chunk = r_b_last;
    end

    crva_merge u_merge (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_adv                (adv),
        .i_side               (merge_in),
        .i_lanes              (q_vec),
        .o_valid              (o_valid),
        .o_result_lanes_0_3   (o_result_lanes_0_3),
        .o_result_lanes_4_7   (o_result_lanes_4_7),
        .o_result_lanes_8_11  (o_result_lanes_8_11),
        .o_result_lanes_12_15 (o_result_lanes_12_15),
        .o_chunk_index        (o_chunk_index),
        .o_row_done           (o_row_done)
    );

`ifndef SYNTHESIS
    // chunk counter stays inside the row
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < eff)
        else $error("chunk counter past the row length");

    // an emitting word in stage b reaches the output register
    a_emit_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_b_valid && r_b_emit) |=> o_valid)
        else $error("emitting word lost before the output register");

    // a frozen accumulate stage keeps its slot address
    a_hold_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && r_a_valid) |=> (r_a_valid && $stable(r_a_pos)))
        else $error("stage a changed while the pipeline was frozen");

    // a result's chunk index lies inside the row
    a_out_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_chunk_index} < eff))
        else $error("result chunk index past the row length");
`endif

endmodule
